### rtl/core/gpioplc_pkg.sv
package gpioplc_pkg;

    localparam int BANKS          = 8;
    localparam int PORTS_PER_BANK = 4;
    localparam int PINS_PER_PORT  = 8;
    localparam int NPORTS         = BANKS * PORTS_PER_BANK;
    localparam int ADDR_W         = (NPORTS > 1) ? $clog2(NPORTS) : 1;

    // stream word layouts
    localparam int IN_W  = 48;
    localparam int OUT_W = 40;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD    = 2'd1,
        ST_LOCKED = 2'd2
    } t_status;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } t_fsm;

    localparam logic [3:0] REG_CFG     = 4'd0;
    localparam logic [3:0] REG_OE      = 4'd1;
    localparam logic [3:0] REG_OUT     = 4'd2;
    localparam logic [3:0] REG_IN      = 4'd3;
    localparam logic [3:0] REG_ISTAT   = 4'd4;
    localparam logic [3:0] REG_IEN     = 4'd5;
    localparam logic [3:0] REG_TRIG    = 4'd6;
    localparam logic [3:0] REG_CLR     = 4'd7;
    localparam logic [3:0] REG_INVALID = 4'hB;

    // one memory entry holds every register of a port
    typedef struct packed {
        logic [23:0] trig;
        logic [7:0]  ien;
        logic [7:0]  ist;
        logic [7:0]  inl;
        logic [7:0]  outl;
        logic [7:0]  oe;
        logic [7:0]  lock;
        logic [7:0]  mode;
    } t_entry;

    // per pin trigger: edge select, polarity, both-edge
    function automatic logic [7:0] detect(input logic [7:0] old_lv, input logic [7:0] now_lv,
                                          input logic [23:0] trig);
        logic [7:0] pol;
        logic [7:0] edg_sel;
        logic [7:0] both;
        logic [7:0] rise;
        logic [7:0] fall;
        logic [7:0] lvl;
        logic [7:0] edg;
        pol     = trig[7:0];
        edg_sel = trig[15:8];
        both    = trig[23:16];
        rise    = ~old_lv & now_lv;
        fall    = old_lv & ~now_lv;
        lvl     = (pol & now_lv) | (~pol & ~now_lv);
        edg     = (both & (rise | fall)) | (~both & ((pol & rise) | (~pol & fall)));
        return (edg_sel & edg) | (~edg_sel & lvl);
    endfunction

endpackage

### rtl/core/gpio_port_controller_with_locks_core.sv
// Banked GPIO controller. Each input word is a register read, a register write or a pin
// sample for one port; each produces exactly one result word (read data, status, the
// port's enabled pending interrupts and a global interrupt flag). All per-port registers
// live in one single-port memory: the entry is read when the word is accepted and the
// modified entry is written back when the result is registered, which waits until the
// output is free. The next word is accepted while a result is still waiting at the
// output. Entries never written read as zero through per-entry valid bits.
module gpio_port_controller_with_locks_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,   // lock_write_open
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // cmd[1:0] bank[4:2] port[6:5] reg_index[10:7] write_data[34:11] pin_levels[42:35]
    input  logic [gpioplc_pkg::IN_W-1:0]  i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // read_data[23:0] status[25:24] port_irq[33:26] any_irq[34]
    output logic [gpioplc_pkg::OUT_W-1:0] o_m_tdata
);

    localparam int AW = gpioplc_pkg::ADDR_W;
    localparam int NP = gpioplc_pkg::NPORTS;

    gpioplc_pkg::t_entry r_mem [NP];
    logic [NP-1:0]       r_vld;
    logic [NP-1:0]       r_pend;
    logic [NP-1:0]       n_pend;

    gpioplc_pkg::t_fsm   r_state;
    gpioplc_pkg::t_fsm   n_state;
    logic                r_lwo;

    gpioplc_pkg::t_cmd   r_cmd;
    logic                r_addr_ok;
    logic [AW-1:0]       r_addr;
    logic [3:0]          r_reg;
    logic [23:0]         r_wd;
    logic [7:0]          r_pins;
    gpioplc_pkg::t_entry r_ent;
    logic                r_ent_ok;

    logic                r_out_valid;
    logic [gpioplc_pkg::OUT_W-1:0] r_out_data;

    logic                w_accept;
    logic                w_fire;
    logic [7:0]          w_idx;
    logic                w_addr_ok;
    logic [AW-1:0]       w_addr;
    gpioplc_pkg::t_entry w_ent;
    gpioplc_pkg::t_entry w_new;
    logic [23:0]         w_rd;
    gpioplc_pkg::t_status w_st;
    logic [7:0]          w_irq;
    logic [7:0]          w_w8;
    logic [7:0]          w_mode;
    logic [7:0]          w_lock;

    // address decode of the incoming word
    always_comb begin
        w_idx     = 8'(i_s_tdata[4:2]) * 8'(gpioplc_pkg::PORTS_PER_BANK) + 8'(i_s_tdata[6:5]);
        w_addr    = w_idx[AW-1:0];
        w_addr_ok = (5'(i_s_tdata[4:2]) < 5'(gpioplc_pkg::BANKS)) &&
                    (4'(i_s_tdata[6:5]) < 4'(gpioplc_pkg::PORTS_PER_BANK));
    end

    // FSM: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gpioplc_pkg::FSM_IDLE: if (w_accept) n_state = gpioplc_pkg::FSM_EXEC;
            gpioplc_pkg::FSM_EXEC: if (w_fire) n_state = gpioplc_pkg::FSM_IDLE;
            default:               n_state = gpioplc_pkg::FSM_IDLE;
        endcase
    end

    // FSM: outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_fire     = 1'b0;
        case (r_state)
            gpioplc_pkg::FSM_IDLE: o_s_tready = 1'b1;
            gpioplc_pkg::FSM_EXEC: w_fire = !r_out_valid || i_m_tready;
            default: ;
        endcase
    end

    assign w_accept = i_s_tvalid && o_s_tready;

    // read-modify of the fetched entry
    always_comb begin
        w_ent  = r_ent_ok ? r_ent : '0;
        w_new  = w_ent;
        w_rd   = '0;
        w_st   = gpioplc_pkg::ST_OK;
        w_w8   = r_wd[7:0];
        w_mode = (w_ent.mode & w_ent.lock) | (w_w8 & ~w_ent.lock);
        w_lock = r_lwo ? r_wd[15:8] : w_ent.lock;
        if (!r_addr_ok || r_cmd == gpioplc_pkg::CMD_NONE) begin
            w_st = gpioplc_pkg::ST_BAD;
        end else if (r_cmd == gpioplc_pkg::CMD_SAMPLE) begin
            w_new.ist = w_ent.ist |
                        (gpioplc_pkg::detect(w_ent.inl, r_pins, w_ent.trig) & w_ent.mode);
            w_new.inl = r_pins;
        end else if (r_reg > gpioplc_pkg::REG_CLR || r_reg == gpioplc_pkg::REG_INVALID) begin
            w_st = gpioplc_pkg::ST_BAD;
        end else if (r_cmd == gpioplc_pkg::CMD_READ) begin
            case (r_reg)
                gpioplc_pkg::REG_CFG:   w_rd = {8'h00, w_ent.lock, w_ent.mode};
                gpioplc_pkg::REG_OE:    w_rd = 24'(w_ent.oe);
                gpioplc_pkg::REG_OUT:   w_rd = 24'(w_ent.outl);
                gpioplc_pkg::REG_IN:    w_rd = 24'(w_ent.inl);
                gpioplc_pkg::REG_ISTAT: w_rd = 24'(w_ent.ist);
                gpioplc_pkg::REG_IEN:   w_rd = 24'(w_ent.ien);
                gpioplc_pkg::REG_TRIG:  w_rd = w_ent.trig;
                default:                w_rd = '0;
            endcase
        end else begin
            case (r_reg)
                gpioplc_pkg::REG_CFG: begin
                    w_new.mode = w_mode;
                    w_new.lock = w_lock;
                    if (w_mode != w_w8 || w_lock != r_wd[15:8]) w_st = gpioplc_pkg::ST_LOCKED;
                end
                gpioplc_pkg::REG_OE: begin
                    w_new.oe = (w_ent.oe & w_ent.lock) | (w_w8 & ~w_ent.lock);
                    if (w_new.oe != w_w8) w_st = gpioplc_pkg::ST_LOCKED;
                end
                gpioplc_pkg::REG_OUT: w_new.outl = w_w8;
                gpioplc_pkg::REG_IEN: w_new.ien  = w_w8;
                gpioplc_pkg::REG_TRIG: w_new.trig = r_wd;
                gpioplc_pkg::REG_CLR: w_new.ist  = w_ent.ist & ~w_w8;
                default: ;   // input and status are read-only
            endcase
        end
        w_irq  = r_addr_ok ? (w_new.ist & w_new.ien) : 8'h00;
        n_pend = r_pend;
        if (r_addr_ok) n_pend[r_addr] = |w_irq;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gpioplc_pkg::FSM_IDLE;
            r_lwo       <= 1'b1;
            r_vld       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_lwo <= i_cfg_wdata;
            if (w_fire) begin
                r_pend      <= n_pend;
                r_out_valid <= 1'b1;
                if (r_addr_ok) r_vld[r_addr] <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and memory
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= gpioplc_pkg::t_cmd'(i_s_tdata[1:0]);
            r_addr_ok <= w_addr_ok;
            r_addr    <= w_addr;
            r_reg     <= i_s_tdata[10:7];
            r_wd      <= i_s_tdata[34:11];
            r_pins    <= i_s_tdata[42:35];
            r_ent     <= r_mem[w_addr];
            r_ent_ok  <= r_vld[w_addr];
        end
        if (w_fire && r_addr_ok) r_mem[r_addr] <= w_new;
        if (w_fire) r_out_data <= {5'b0, |n_pend, w_irq, w_st, w_rd};
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == gpioplc_pkg::FSM_EXEC)
        else $error("accepted word did not start execution");

    a_fire_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_state == gpioplc_pkg::FSM_IDLE && r_out_valid))
        else $error("result not presented after execution");

    a_any_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[34] == |r_pend))
        else $error("any_irq disagrees with pending ports");

    a_no_ready_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gpioplc_pkg::FSM_EXEC) |-> !o_s_tready)
        else $error("input ready while an item is in flight");
`endif

endmodule
